### src/jfd_pkg.sv
// shared types and constants for the jpeg frame deframer
package jfd_pkg;

  localparam int unsigned MaxLenWidth = 25;
  localparam logic [MaxLenWidth-1:0] MaxLenReset = 25'd65536;

  localparam logic [31:0] HdrMagicValue = 32'h55AA55AA;
  localparam logic [31:0] HdrBytes = 32'd12;
  localparam logic [31:0] LenMin = 32'd4;
  localparam logic [7:0] MarkFf = 8'hFF;
  localparam logic [7:0] MarkSoi = 8'hD8;
  localparam logic [7:0] MarkEoi = 8'hD9;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DRAIN   = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    ST_NONE         = 3'd0,
    ST_DELIVERED    = 3'd1,
    ST_BAD_HEADER   = 3'd2,
    ST_BAD_MARKERS  = 3'd3,
    ST_SINK_REFUSED = 3'd4
  } frame_status_e;

  typedef struct packed {
    logic          payload_valid;
    logic [7:0]    payload_byte;
    frame_status_e frame_status;
    logic [15:0]   frame_index;
    logic [31:0]   frame_length;
    logic [31:0]   bytes_received;
    logic [31:0]   frames_delivered;
    logic [31:0]   frames_lost;
  } result_t;

endpackage

### src/jfd_core.sv
// deframer state and per-word result logic
module jfd_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic                              req_type_i,
  input  logic [7:0]                        data_byte_i,
  input  logic                              sink_ready_i,
  input  logic                              cfg_wr_en_i,
  input  logic [jfd_pkg::MaxLenWidth-1:0]   cfg_wdata_i,
  output jfd_pkg::result_t                  res_o
);

  logic [jfd_pkg::MaxLenWidth-1:0] max_len_q;
  jfd_pkg::phase_e phase_q, phase_d;
  logic [31:0] off_q, off_d;
  logic [31:0] magic_q, magic_d;
  logic [31:0] len_q, len_d;
  logic [15:0] index_q, index_d;
  logic [15:0] rsvd_q, rsvd_d;
  logic        smo_q, smo_d;
  logic [15:0] last2_q, last2_d;
  logic [31:0] bytes_q, bytes_d;
  logic [31:0] ok_q, ok_d;
  logic [31:0] drop_q, drop_d;
  logic        pv;
  logic [7:0]  pb;
  jfd_pkg::frame_status_e status;
  logic [31:0] off_inc;
  logic        hdr_ok;

  assign off_inc = off_q + 32'd1;

  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    magic_d = magic_q;
    len_d   = len_q;
    index_d = index_q;
    rsvd_d  = rsvd_q;
    smo_d   = smo_q;
    last2_d = last2_q;
    bytes_d = bytes_q;
    ok_d    = ok_q;
    drop_d  = drop_q;
    pv      = 1'b0;
    pb      = 8'd0;
    status  = jfd_pkg::ST_NONE;
    hdr_ok  = 1'b0;
    if (req_type_i) begin
      phase_d = jfd_pkg::PH_HEADER;
      off_d   = 32'd0;
    end else begin
      bytes_d = bytes_q + 32'd1;
      case (phase_q)
        jfd_pkg::PH_PAYLOAD: begin
          pv = 1'b1;
          pb = data_byte_i;
          if (off_q == 32'd0) begin
            smo_d = (data_byte_i == jfd_pkg::MarkFf);
          end else if (off_q == 32'd1) begin
            smo_d = smo_q && (data_byte_i == jfd_pkg::MarkSoi);
          end
          last2_d = {last2_q[7:0], data_byte_i};
          if (off_inc >= len_q) begin
            if (!smo_d || last2_d != {jfd_pkg::MarkFf, jfd_pkg::MarkEoi}) begin
              status = jfd_pkg::ST_BAD_MARKERS;
              drop_d = drop_q + 32'd1;
            end else if (!sink_ready_i) begin
              status = jfd_pkg::ST_SINK_REFUSED;
              drop_d = drop_q + 32'd1;
            end else begin
              status = jfd_pkg::ST_DELIVERED;
              ok_d   = ok_q + 32'd1;
            end
            phase_d = jfd_pkg::PH_HEADER;
            off_d   = 32'd0;
          end else begin
            off_d = off_inc;
          end
        end
        jfd_pkg::PH_DRAIN: begin
          if (off_inc >= len_q) begin
            phase_d = jfd_pkg::PH_HEADER;
            off_d   = 32'd0;
          end else begin
            off_d = off_inc;
          end
        end
        default: begin
          // header bytes land in their little-endian lane
          if (off_q < 32'd4) begin
            magic_d[8*off_q[1:0] +: 8] = data_byte_i;
          end else if (off_q < 32'd8) begin
            len_d[8*off_q[1:0] +: 8] = data_byte_i;
          end else if (off_q < 32'd10) begin
            index_d[8*off_q[0] +: 8] = data_byte_i;
          end else begin
            rsvd_d[8*off_q[0] +: 8] = data_byte_i;
          end
          hdr_ok = (magic_d == jfd_pkg::HdrMagicValue) && (rsvd_d == 16'd0) &&
                   (len_d >= jfd_pkg::LenMin) &&
                   (len_d <= {{(32-jfd_pkg::MaxLenWidth){1'b0}}, max_len_q});
          if (off_inc >= jfd_pkg::HdrBytes) begin
            off_d = 32'd0;
            if (hdr_ok) begin
              phase_d = jfd_pkg::PH_PAYLOAD;
              smo_d   = 1'b0;
              last2_d = 16'd0;
            end else begin
              status  = jfd_pkg::ST_BAD_HEADER;
              drop_d  = drop_q + 32'd1;
              phase_d = (len_d == 32'd0) ? jfd_pkg::PH_HEADER : jfd_pkg::PH_DRAIN;
            end
          end else begin
            phase_d = jfd_pkg::PH_HEADER;
            off_d   = off_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= jfd_pkg::MaxLenReset;
    end else if (cfg_wr_en_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jfd_pkg::PH_HEADER;
      off_q   <= 32'd0;
      magic_q <= 32'd0;
      len_q   <= 32'd0;
      index_q <= 16'd0;
      rsvd_q  <= 16'd0;
      smo_q   <= 1'b0;
      last2_q <= 16'd0;
      bytes_q <= 32'd0;
      ok_q    <= 32'd0;
      drop_q  <= 32'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      off_q   <= off_d;
      magic_q <= magic_d;
      len_q   <= len_d;
      index_q <= index_d;
      rsvd_q  <= rsvd_d;
      smo_q   <= smo_d;
      last2_q <= last2_d;
      bytes_q <= bytes_d;
      ok_q    <= ok_d;
      drop_q  <= drop_d;
    end
  end

  always_comb begin
    res_o.payload_valid    = pv;
    res_o.payload_byte     = pb;
    res_o.frame_status     = status;
    res_o.frame_index      = index_d;
    res_o.frame_length     = len_d;
    res_o.bytes_received   = bytes_d;
    res_o.frames_delivered = ok_d;
    res_o.frames_lost      = drop_d;
  end

endmodule

### src/jfd_out_buf.sv
// two-entry result buffer between the deframer and the output channel
module jfd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jfd_pkg::result_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             stall_i,
  output jfd_pkg::result_t data_o
);

  jfd_pkg::result_t ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o && !stall_i;
  assign data_o  = ent_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

### src/jpeg_frame_deframer.sv
// jpeg frame deframer top level
// output: each result word is registered in the result buffer, then offered
// throughput: one word per cycle while in_stall_o is low; the two-entry result
// buffer keeps input open with one result held, in_stall_o rises only with two
// reset: async active low, phase to header, headers and counters to zero,
// max_frame_length to 65536; no clearing pass
module jpeg_frame_deframer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_wr_en_i,
  input  logic [jfd_pkg::MaxLenWidth-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            sink_ready_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            payload_valid_o,
  output logic [7:0]                      payload_byte_o,
  output logic [2:0]                      frame_status_o,
  output logic [15:0]                     frame_index_o,
  output logic [31:0]                     frame_length_o,
  output logic [31:0]                     bytes_received_o,
  output logic [31:0]                     frames_delivered_o,
  output logic [31:0]                     frames_lost_o
);

  logic             accept;
  logic             full;
  jfd_pkg::result_t core_res;
  jfd_pkg::result_t out_res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  jfd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .sink_ready_i (sink_ready_i),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_o        (core_res)
  );

  jfd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (core_res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_res)
  );

  assign payload_valid_o    = out_res.payload_valid;
  assign payload_byte_o     = out_res.payload_byte;
  assign frame_status_o     = out_res.frame_status;
  assign frame_index_o      = out_res.frame_index;
  assign frame_length_o     = out_res.frame_length;
  assign bytes_received_o   = out_res.bytes_received;
  assign frames_delivered_o = out_res.frames_delivered;
  assign frames_lost_o      = out_res.frames_lost;

endmodule

### bench/tb_jpeg_frame_deframer.sv
// self-checking testbench for jpeg_frame_deframer: random framed byte streams against a mirror
class deframer_mirror;
  jfd_pkg::result_t owed_words[$];
  logic [jfd_pkg::MaxLenWidth-1:0] max_len;
  jfd_pkg::phase_e ph;
  logic [31:0] offset;
  logic [31:0] magic;
  logic [31:0] len;
  logic [15:0] idx;
  logic [15:0] rsv;
  logic soi_ok;
  logic [15:0] tail;
  logic [31:0] n_bytes;
  logic [31:0] n_ok;
  logic [31:0] n_drop;
  int unsigned errors;
  int unsigned checked;
  int unsigned status_seen[5];

  function new();
    max_len = jfd_pkg::MaxLenReset;
    ph = jfd_pkg::PH_HEADER;
    offset = '0;
    magic = '0;
    len = '0;
    idx = '0;
    rsv = '0;
    soi_ok = 1'b0;
    tail = '0;
    n_bytes = '0;
    n_ok = '0;
    n_drop = '0;
    errors = 0;
    checked = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  task absorb_word(input logic req, input logic [7:0] b, input logic rdy);
    jfd_pkg::result_t r;
    int kk;
    r = '0;
    r.frame_status = jfd_pkg::ST_NONE;
    if (req) begin
      ph = jfd_pkg::PH_HEADER;
      offset = '0;
    end else begin
      n_bytes = n_bytes + 32'd1;
      case (ph)
        jfd_pkg::PH_PAYLOAD: begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          if (offset == 32'd0) soi_ok = (b == jfd_pkg::MarkFf);
          else if (offset == 32'd1) soi_ok = soi_ok && (b == jfd_pkg::MarkSoi);
          tail = {tail[7:0], b};
          if (offset + 32'd1 >= len) begin
            if (!soi_ok || tail != {jfd_pkg::MarkFf, jfd_pkg::MarkEoi}) begin
              r.frame_status = jfd_pkg::ST_BAD_MARKERS;
              n_drop = n_drop + 32'd1;
            end else if (!rdy) begin
              r.frame_status = jfd_pkg::ST_SINK_REFUSED;
              n_drop = n_drop + 32'd1;
            end else begin
              r.frame_status = jfd_pkg::ST_DELIVERED;
              n_ok = n_ok + 32'd1;
            end
            ph = jfd_pkg::PH_HEADER;
            offset = '0;
          end else begin
            offset = offset + 32'd1;
          end
        end
        jfd_pkg::PH_DRAIN: begin
          if (offset + 32'd1 >= len) begin
            ph = jfd_pkg::PH_HEADER;
            offset = '0;
          end else begin
            offset = offset + 32'd1;
          end
        end
        default: begin
          // header bytes land in their little-endian lane
          kk = int'(offset);
          if (kk < 4) magic[8*kk +: 8] = b;
          else if (kk < 8) len[8*(kk-4) +: 8] = b;
          else if (kk < 10) idx[8*(kk-8) +: 8] = b;
          else rsv[8*((kk-10) & 1) +: 8] = b;
          if (offset + 32'd1 >= jfd_pkg::HdrBytes) begin
            offset = '0;
            if (magic == jfd_pkg::HdrMagicValue && rsv == 16'd0 &&
                len >= jfd_pkg::LenMin && len <= 32'(max_len)) begin
              ph = jfd_pkg::PH_PAYLOAD;
              soi_ok = 1'b0;
              tail = '0;
            end else begin
              r.frame_status = jfd_pkg::ST_BAD_HEADER;
              n_drop = n_drop + 32'd1;
              ph = (len == 32'd0) ? jfd_pkg::PH_HEADER : jfd_pkg::PH_DRAIN;
            end
          end else begin
            ph = jfd_pkg::PH_HEADER;
            offset = offset + 32'd1;
          end
        end
      endcase
    end
    r.frame_index = idx;
    r.frame_length = len;
    r.bytes_received = n_bytes;
    r.frames_delivered = n_ok;
    r.frames_lost = n_drop;
    status_seen[r.frame_status]++;
    owed_words.push_back(r);
  endtask

  task report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (errors < 40)
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task check_word(input jfd_pkg::result_t got);
    jfd_pkg::result_t want;
    checked++;
    if (owed_words.size() == 0) begin
      report("result word with nothing owed", 32'd0, 32'd0);
      return;
    end
    want = owed_words.pop_front();
    if (got.payload_valid !== want.payload_valid)
      report("payload_valid", 32'(got.payload_valid), 32'(want.payload_valid));
    if (got.payload_byte !== want.payload_byte)
      report("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
    if (got.frame_status !== want.frame_status)
      report("frame_status", 32'(got.frame_status), 32'(want.frame_status));
    if (got.frame_index !== want.frame_index)
      report("frame_index", 32'(got.frame_index), 32'(want.frame_index));
    if (got.frame_length !== want.frame_length)
      report("frame_length", got.frame_length, want.frame_length);
    if (got.bytes_received !== want.bytes_received)
      report("bytes_received", got.bytes_received, want.bytes_received);
    if (got.frames_delivered !== want.frames_delivered)
      report("frames_delivered", got.frames_delivered, want.frames_delivered);
    if (got.frames_lost !== want.frames_lost)
      report("frames_lost", got.frames_lost, want.frames_lost);
  endtask
endclass

module tb_jpeg_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumPhases = 8;
  localparam int unsigned WordsPerPhase = 200;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned LongHold = 400;

  logic clk_i;
  logic rst_ni;
  logic cfg_wr_en_i;
  logic [jfd_pkg::MaxLenWidth-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  logic req_type_i;
  logic [7:0] data_byte_i;
  logic sink_ready_i;
  logic out_valid_o;
  logic out_stall_i;
  logic payload_valid_o;
  logic [7:0] payload_byte_o;
  logic [2:0] frame_status_o;
  logic [15:0] frame_index_o;
  logic [31:0] frame_length_o;
  logic [31:0] bytes_received_o;
  logic [31:0] frames_delivered_o;
  logic [31:0] frames_lost_o;

  deframer_mirror sb;
  jfd_pkg::result_t got_word;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  int unsigned words_sent;
  int unsigned cfg_writes;
  int unsigned idle_cycles;

  int unsigned phase_max[NumPhases] = '{65536, 4, 16777216, 3, 64, 0, 16777215, 40};
  int unsigned phase_send_idle[NumPhases] = '{0, 48, 0, 11, 0, 48, 0, 11};
  int unsigned phase_stall[NumPhases] = '{0, 0, 48, 11, 0, 0, 48, 11};

  jpeg_frame_deframer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_wr_en_i        (cfg_wr_en_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .data_byte_i        (data_byte_i),
    .sink_ready_i       (sink_ready_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .payload_valid_o    (payload_valid_o),
    .payload_byte_o     (payload_byte_o),
    .frame_status_o     (frame_status_o),
    .frame_index_o      (frame_index_o),
    .frame_length_o     (frame_length_o),
    .bytes_received_o   (bytes_received_o),
    .frames_delivered_o (frames_delivered_o),
    .frames_lost_o      (frames_lost_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_word.payload_valid = payload_valid_o;
      got_word.payload_byte = payload_byte_o;
      got_word.frame_status = jfd_pkg::frame_status_e'(frame_status_o);
      got_word.frame_index = frame_index_o;
      got_word.frame_length = frame_length_o;
      got_word.bytes_received = bytes_received_o;
      got_word.frames_delivered = frames_delivered_o;
      got_word.frames_lost = frames_lost_o;
      sb.check_word(got_word);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb_jpeg_frame_deframer: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic req, input logic [7:0] b, input logic rdy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    data_byte_i <= b;
    sink_ready_i <= rdy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.absorb_word(req, b, rdy);
    words_sent++;
  endtask

  task automatic send_resync();
    send_word(1'b1, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_header(input logic [31:0] magic, input logic [31:0] len,
                             input logic [15:0] idx, input logic [15:0] rsv);
    logic [95:0] hdr;
    hdr = {rsv, idx, len, magic};
    for (int i = 0; i < 12; i++) send_word(1'b0, hdr[8*i +: 8], 1'($urandom));
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_max(input logic [jfd_pkg::MaxLenWidth-1:0] v);
    quiesce();
    cfg_wr_en_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    sb.max_len = v;
    cfg_writes++;
  endtask

  // one framed unit of stream, mostly well formed, sometimes broken or cut by a resync
  task automatic send_frame();
    int unsigned pick;
    int unsigned cap;
    int unsigned bad_pos;
    longint unsigned cut;
    longint unsigned total;
    logic [31:0] magic;
    logic [31:0] len;
    logic [31:0] j;
    logic [15:0] idx;
    logic [15:0] rsv;
    logic [95:0] hdr;
    logic [7:0] b;
    logic rdy;
    pick = $urandom_range(99);
    magic = jfd_pkg::HdrMagicValue;
    rsv = '0;
    idx = 16'($urandom);
    cap = (sb.max_len < 40) ? int'(sb.max_len) : 40;
    len = (cap >= 4) ? $urandom_range(cap, 4) : $urandom_range(12, 4);
    cut = 0;
    bad_pos = ($urandom_range(4) == 0) ? $urandom_range(3) : 4;
    if (pick < 8) begin
      magic ^= 32'd1 << $urandom_range(31);
    end else if (pick < 14) begin
      rsv = 16'($urandom_range(16'hFFFF, 1));
    end else if (pick < 20) begin
      len = $urandom_range(3);
    end else if (pick < 26) begin
      // length just past the maximum
      len = 32'(sb.max_len) + $urandom_range(6, 1);
      if (sb.max_len >= 1000) cut = 12 + $urandom_range(5, 1);
    end else if (pick < 32) begin
      cut = $urandom_range(11 + len, 1);
    end else if (pick < 36) begin
      len = $urandom_range(1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
      cut = 12 + $urandom_range(5, 1);
    end else if (pick < 40) begin
      // line noise, then resync
      repeat ($urandom_range(11, 1)) send_word(1'b0, 8'($urandom), 1'($urandom));
      send_resync();
      return;
    end
    hdr = {rsv, idx, len, magic};
    total = 64'(len) + 64'd12;
    for (longint unsigned i = 0; i < total; i++) begin
      if (cut != 0 && i == cut) begin
        send_resync();
        return;
      end
      rdy = 1'($urandom);
      if (i < 12) begin
        b = hdr[8*i +: 8];
      end else begin
        j = 32'(i - 12);
        b = 8'($urandom);
        if (j == 0) b = jfd_pkg::MarkFf;
        else if (j == 1) b = jfd_pkg::MarkSoi;
        else if (j == len - 2) b = jfd_pkg::MarkFf;
        else if (j == len - 1) b = jfd_pkg::MarkEoi;
        if ((bad_pos == 0 && j == 0) || (bad_pos == 1 && j == 1) ||
            (bad_pos == 2 && j == len - 2) || (bad_pos == 3 && j == len - 1))
          b ^= 8'($urandom_range(255, 1));
        if (j == len - 1) rdy = ($urandom_range(3) != 0);
      end
      send_word(1'b0, b, rdy);
    end
  endtask

  initial begin
    int unsigned phase_start;
    sb = new();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    words_sent = 0;
    cfg_writes = 0;
    idle_cycles = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    req_type_i <= 1'b0;
    data_byte_i <= '0;
    sink_ready_i <= 1'b0;
    cfg_wr_en_i <= 1'b0;
    cfg_wdata_i <= '0;
    out_stall_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shortest good frame under the reset maximum
    send_header(jfd_pkg::HdrMagicValue, 32'd4, 16'hFFFF, 16'h0000);
    send_word(1'b0, jfd_pkg::MarkFf, 1'b0);
    send_word(1'b0, jfd_pkg::MarkSoi, 1'b0);
    send_word(1'b0, jfd_pkg::MarkFf, 1'b0);
    send_word(1'b0, jfd_pkg::MarkEoi, 1'b1);
    // partial header then resync
    send_word(1'b0, 8'hAA, 1'b1);
    send_word(1'b0, 8'h00, 1'b0);
    send_resync();

    // maximum lowered while a frame is in flight
    write_max(25'd64);
    send_header(jfd_pkg::HdrMagicValue, 32'd10, 16'h0001, 16'h0000);
    send_word(1'b0, jfd_pkg::MarkFf, 1'b0);
    send_word(1'b0, jfd_pkg::MarkSoi, 1'b0);
    send_word(1'b0, 8'h00, 1'b0);
    write_max(25'd4);
    repeat (5) send_word(1'b0, 8'($urandom), 1'($urandom));
    send_word(1'b0, jfd_pkg::MarkFf, 1'b0);
    send_word(1'b0, jfd_pkg::MarkEoi, 1'b1);

    for (int p = 0; p < NumPhases; p++) begin
      write_max(phase_max[p][jfd_pkg::MaxLenWidth-1:0]);
      send_idle_pct = phase_send_idle[p];
      stall_pct = phase_stall[p];
      if (p == 4) hold_left = LongHold;
      phase_start = words_sent;
      while (words_sent - phase_start < WordsPerPhase) send_frame();
    end

    quiesce();
    repeat (4) @(posedge clk_i);
    $display("run covered %0d words under %0d max_frame_length writes, %0d results checked",
             words_sent, cfg_writes, sb.checked);
    $display("frames: %0d delivered, %0d bad header, %0d bad markers, %0d refused by sink",
             sb.status_seen[jfd_pkg::ST_DELIVERED], sb.status_seen[jfd_pkg::ST_BAD_HEADER],
             sb.status_seen[jfd_pkg::ST_BAD_MARKERS], sb.status_seen[jfd_pkg::ST_SINK_REFUSED]);
    if (sb.errors == 0) begin
      $display("tb_jpeg_frame_deframer: clean");
    end else begin
      $display("tb_jpeg_frame_deframer: errors");
    end
    $finish;
  end

endmodule

### files.f
src/jfd_pkg.sv
src/jfd_core.sv
src/jfd_out_buf.sv
src/jpeg_frame_deframer.sv
bench/tb_jpeg_frame_deframer.sv
